FILE: design/resistor_ladder_button_events_core_macros.svh
// ----------------------------------------------------------------------------
// resistor ladder button events: assertion macros
// shared check helpers, used by the core and not by its submodules
// ----------------------------------------------------------------------------
`ifndef RESISTOR_LADDER_BUTTON_EVENTS_CORE_MACROS_SVH
`define RESISTOR_LADDER_BUTTON_EVENTS_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define RLBE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlbe check failed");

// next-cycle implication, off while reset is high
`define RLBE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlbe check failed");

`endif

FILE: design/rlbe_pkg.sv
// ----------------------------------------------------------------------------
// rlbe_pkg
// widths, codes and shared types of the button event core
// ----------------------------------------------------------------------------
`default_nettype none

package rlbe_pkg;

   localparam int TimeBits    = 32;
   localparam int AdcBits     = 10;
   localparam int MsBits      = 16;
   localparam int EventBits   = 3;
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 16;
   localparam int ButtonBits  = 2;

   // config register indexes
   localparam logic [CsrIdxBits-1:0] CsrThresholdLow  = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrThresholdHigh = 2'd1;
   localparam logic [CsrIdxBits-1:0] CsrDebounceMs    = 2'd2;
   localparam logic [CsrIdxBits-1:0] CsrLongPressMs   = 2'd3;

   // config reset values
   localparam logic [AdcBits-1:0] ThresholdLowReset  = AdcBits'(300);
   localparam logic [AdcBits-1:0] ThresholdHighReset = AdcBits'(700);
   localparam logic [MsBits-1:0]  DebounceMsReset    = MsBits'(50);
   localparam logic [MsBits-1:0]  LongPressMsReset   = MsBits'(1000);

   // item kinds
   localparam logic KindSample  = 1'b0;
   localparam logic KindConsume = 1'b1;

   // button codes
   localparam logic [ButtonBits-1:0] BtnNone = 2'd0;
   localparam logic [ButtonBits-1:0] Btn1    = 2'd1;
   localparam logic [ButtonBits-1:0] Btn2    = 2'd2;

   // event codes
   localparam logic [EventBits-1:0] EvNone      = 3'd0;
   localparam logic [EventBits-1:0] EvDebounced = 3'd1;
   localparam logic [EventBits-1:0] EvShort1    = 3'd2;
   localparam logic [EventBits-1:0] EvShort2    = 3'd3;
   localparam logic [EventBits-1:0] EvLong1     = 3'd4;
   localparam logic [EventBits-1:0] EvLong2     = 3'd5;

   typedef struct packed {
      logic [AdcBits-1:0] thr_low;
      logic [AdcBits-1:0] thr_high;
      logic [MsBits-1:0]  debounce_ms;
      logic [MsBits-1:0]  long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic                kind;
      logic                block_input;
      logic [AdcBits-1:0]  adc_value;
      logic [TimeBits-1:0] now_ms;
   } item_type;

endpackage

`default_nettype wire

FILE: design/rlbe_csr.sv
// ----------------------------------------------------------------------------
// rlbe_csr
// threshold and timing registers behind the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module rlbe_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [rlbe_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire logic [rlbe_pkg::CsrDataBits-1:0]    csr_data,
   output rlbe_pkg::cfg_type                        cfg
);

   rlbe_pkg::cfg_type cfg_ff;
   rlbe_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rlbe_pkg::CsrThresholdLow: begin
               cfg_in.thr_low = csr_data[rlbe_pkg::AdcBits-1:0];
            end
            rlbe_pkg::CsrThresholdHigh: begin
               cfg_in.thr_high = csr_data[rlbe_pkg::AdcBits-1:0];
            end
            rlbe_pkg::CsrDebounceMs: begin
               cfg_in.debounce_ms = csr_data[rlbe_pkg::MsBits-1:0];
            end
            rlbe_pkg::CsrLongPressMs: begin
               cfg_in.long_press_ms = csr_data[rlbe_pkg::MsBits-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_low       <= rlbe_pkg::ThresholdLowReset;
         cfg_ff.thr_high      <= rlbe_pkg::ThresholdHighReset;
         cfg_ff.debounce_ms   <= rlbe_pkg::DebounceMsReset;
         cfg_ff.long_press_ms <= rlbe_pkg::LongPressMsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/rlbe_event.sv
// ----------------------------------------------------------------------------
// rlbe_event
// press tracking state and event decision for one registered word
// ----------------------------------------------------------------------------
`default_nettype none

module rlbe_event (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire rlbe_pkg::item_type                  item,
   input  wire rlbe_pkg::cfg_type                   cfg,
   output logic [rlbe_pkg::EventBits-1:0]           event_res
);

   typedef struct packed {
      logic                                pressed;
      logic [rlbe_pkg::ButtonBits-1:0]     active_button;
      logic [rlbe_pkg::TimeBits-1:0]       press_start;
      logic                                debounce_fired;
      logic                                long_timing;
      logic [rlbe_pkg::TimeBits-1:0]       long_start;
      logic                                long_seen;
      logic                                press_consumed;
   } press_state_type;

   press_state_type                     st_ff;
   press_state_type                     st_in;
   logic [rlbe_pkg::ButtonBits-1:0]     button;
   logic [rlbe_pkg::TimeBits-1:0]       el_press;
   logic [rlbe_pkg::TimeBits-1:0]       el_long;
   logic                                deb_done;
   logic                                long_done;

   // ladder classification
   always_comb begin
      button = rlbe_pkg::BtnNone;
      if (item.adc_value < cfg.thr_low) begin
         button = rlbe_pkg::Btn2;
      end else if (item.adc_value < cfg.thr_high) begin
         button = rlbe_pkg::Btn1;
      end
   end

   // wrapping time differences
   assign el_press  = item.now_ms - st_ff.press_start;
   assign el_long   = item.now_ms - st_ff.long_start;
   assign deb_done  = el_press > rlbe_pkg::TimeBits'(cfg.debounce_ms);
   assign long_done = el_long > rlbe_pkg::TimeBits'(cfg.long_press_ms);

   always_comb begin
      st_in     = st_ff;
      event_res = rlbe_pkg::EvNone;
      if (item.kind == rlbe_pkg::KindConsume) begin
         st_in.press_consumed = 1'b1;
      end else if (!item.block_input) begin
         if (button != rlbe_pkg::BtnNone) begin
            if (!st_ff.pressed) begin
               st_in.pressed        = 1'b1;
               st_in.press_start    = item.now_ms;
               st_in.active_button  = button;
               st_in.debounce_fired = 1'b0;
            end else if (deb_done) begin
               if (!st_ff.debounce_fired) begin
                  st_in.debounce_fired = 1'b1;
                  event_res            = rlbe_pkg::EvDebounced;
               end else if (!st_ff.press_consumed) begin
                  if (!st_ff.long_timing) begin
                     st_in.long_timing = 1'b1;
                     st_in.long_start  = item.now_ms;
                  end else if (long_done) begin
                     st_in.long_seen  = 1'b1;
                     st_in.long_start = item.now_ms;
                     event_res = (st_ff.active_button == rlbe_pkg::Btn1) ?
                                 rlbe_pkg::EvLong1 : rlbe_pkg::EvLong2;
                  end
               end
            end
         end else if (st_ff.pressed) begin
            // release: short press unless long seen or consumed
            if (!st_ff.long_seen && !st_ff.press_consumed) begin
               event_res = (st_ff.active_button == rlbe_pkg::Btn1) ?
                           rlbe_pkg::EvShort1 : rlbe_pkg::EvShort2;
            end
            st_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/resistor_ladder_button_events_core.sv
// ----------------------------------------------------------------------------
// resistor_ladder_button_events_core: two-button ladder debounce and press events
// path: input register, then result register, which drives rsp
// throughput: one word per cycle while rsp is not stalled, set by both registers
// reset: synchronous, clears press state, both valid flags and loads csr defaults
// ----------------------------------------------------------------------------
`default_nettype none

`include "resistor_ladder_button_events_core_macros.svh"

module resistor_ladder_button_events_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_kind,
   input  wire logic                                req_block_input,
   input  wire logic [rlbe_pkg::AdcBits-1:0]        req_adc_value,
   input  wire logic [rlbe_pkg::TimeBits-1:0]       req_now_ms,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [rlbe_pkg::EventBits-1:0]           rsp_event_res,
   // config write port
   input  wire logic                                csr_wr_en,
   input  wire logic [rlbe_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire logic [rlbe_pkg::CsrDataBits-1:0]    csr_data
);

   rlbe_pkg::cfg_type                   cfg;
   rlbe_pkg::item_type                  item_ff;
   rlbe_pkg::item_type                  item_in;
   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [rlbe_pkg::EventBits-1:0]      rsp_event_ff;
   logic [rlbe_pkg::EventBits-1:0]      rsp_event_in;
   logic [rlbe_pkg::EventBits-1:0]      event_res;
   logic                                advance;
   logic                                req_take;

   // config registers
   rlbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // stage 1 word moves to the result register when that register is free
   // or being drained this cycle; press state updates on the same edge
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // input register accepts a new word when it is empty or its current one is leaving
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in.kind        = req_kind;
      item_in.block_input = req_block_input;
      item_in.adc_value   = req_adc_value;
      item_in.now_ms      = req_now_ms;
   end

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // press tracking and event decision
   rlbe_event u_event (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .event_res (event_res)
   );

   // result register holds its word while the consumer stalls
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_event_in = advance ? event_res : rsp_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      rsp_event_ff <= rsp_event_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;

   // an empty input register never pushes back
   `RLBE_ASSERT_IMP(a_no_stall_when_empty, clock, reset, !s1_valid_ff, !req_stall)
   // every word leaving stage 1 lands in the result register
   `RLBE_ASSERT_NXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff)
   // consume requests and blocked samples never raise an event
   `RLBE_ASSERT_NXT(a_quiet_words, clock, reset,
      advance && (item_ff.kind == rlbe_pkg::KindConsume || item_ff.block_input),
      rsp_event_ff == rlbe_pkg::EvNone)

endmodule

`default_nettype wire
